// ===== design/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

  // Geometry of the bitmap.
  localparam int unsigned FRAME_TOTAL = 4096;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned MAP_WORDS   = FRAME_TOTAL / WORD_BITS;
  localparam int unsigned WORD_AW     = $clog2(WORD_BITS);
  localparam int unsigned WORD_CW     = WORD_AW + 1;
  localparam int unsigned MAP_AW      = $clog2(MAP_WORDS);

  // Field widths of the request and result words.
  localparam int unsigned FRAME_W = 13;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned MODE_W  = 2;

  localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAME_TOTAL - 1);
  localparam logic [FRAME_W-1:0] MAP_END    = FRAME_W'(FRAME_TOTAL);

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MARK   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Result status codes.
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OOM = 1'b1;

  // Configuration register indexes.
  localparam logic REG_RANGE_START = 1'b0;
  localparam logic REG_RANGE_LIMIT = 1'b1;

  // One step of the first-fit search over the current word.
  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] next_f;
    logic [FRAME_W-1:0] next_run;
    logic [FRAME_W-1:0] next_cand;
  } scan_step_t;

endpackage

`default_nettype wire

// ===== design/bfa_bitmap_mem.sv =====
`default_nettype none

module bfa_bitmap_mem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [bfa_pkg::MAP_AW-1:0]    rd_addr_i,
  output logic      [bfa_pkg::WORD_BITS-1:0] rd_data_o,
  input  wire logic                          wr_en_i,
  input  wire logic [bfa_pkg::MAP_AW-1:0]    wr_addr_i,
  input  wire logic [bfa_pkg::WORD_BITS-1:0] wr_data_i
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvalid_q;

  // A word never written since reset reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== design/bfa_word_unit.sv =====
`default_nettype none

module bfa_word_unit (
  input  wire logic [bfa_pkg::WORD_BITS-1:0] word_i,
  input  wire logic [bfa_pkg::FRAME_W-1:0]   f_i,
  input  wire logic [bfa_pkg::FRAME_W-1:0]   end_i,
  input  wire logic [bfa_pkg::FRAME_W-1:0]   run_i,
  input  wire logic [bfa_pkg::FRAME_W-1:0]   cand_i,
  input  wire logic [bfa_pkg::FRAME_W-1:0]   count_i,
  input  wire logic [bfa_pkg::INDEX_W-1:0]   last_i,
  output bfa_pkg::scan_step_t                step_o,
  output logic      [bfa_pkg::WORD_BITS-1:0] mask_o
);
  import bfa_pkg::*;

  logic [WORD_AW-1:0]   pos;
  logic [WORD_BITS-1:0] shifted;
  logic [WORD_CW-1:0]   word_rem;
  logic [FRAME_W-1:0]   lim_rem;
  logic [WORD_CW-1:0]   lim;
  logic [WORD_CW-1:0]   used_at;
  logic [WORD_CW-1:0]   span;
  logic                 hit;
  logic [FRAME_W-1:0]   run_sum;
  logic [WORD_AW-1:0]   end_bit;

  // Priority encoder: position of the lowest used frame, WORD_BITS if none.
  function automatic logic [WORD_CW-1:0] first_one(input logic [WORD_BITS-1:0] v);
    logic [WORD_CW-1:0] k;
    k = WORD_CW'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        k = WORD_CW'(i);
      end
    end
    return k;
  endfunction

  always_comb begin
    pos      = f_i[WORD_AW-1:0];
    shifted  = word_i >> pos;
    word_rem = WORD_CW'(WORD_BITS) - {1'b0, pos};
    lim_rem  = end_i - f_i;
    lim      = (lim_rem < FRAME_W'(word_rem)) ? lim_rem[WORD_CW-1:0] : word_rem;
    used_at  = first_one(shifted);
    hit      = used_at < lim;
    span     = hit ? used_at : lim;
    run_sum  = run_i + FRAME_W'(span);

    step_o.found = run_sum >= count_i;
    if (hit) begin
      step_o.next_f    = f_i + FRAME_W'(used_at) + FRAME_W'(1);
      step_o.next_run  = '0;
      step_o.next_cand = f_i + FRAME_W'(used_at) + FRAME_W'(1);
    end else begin
      step_o.next_f    = f_i + FRAME_W'(span);
      step_o.next_run  = run_sum;
      step_o.next_cand = cand_i;
    end
  end

  // Bit mask of the run's frames that fall into the current word.
  always_comb begin
    end_bit = (f_i[INDEX_W-1:WORD_AW] == last_i[INDEX_W-1:WORD_AW]) ?
              last_i[WORD_AW-1:0] : WORD_AW'(WORD_BITS - 1);
    mask_o  = ({WORD_BITS{1'b1}} << f_i[WORD_AW-1:0]) &
              ({WORD_BITS{1'b1}} >> (WORD_AW'(WORD_BITS - 1) - end_bit));
  end

endmodule

`default_nettype wire

// ===== design/bitmap_frame_allocator.sv =====
`default_nettype none

// A free or mark reads and writes back each bitmap word it touches, then reports; an allocate
// reads each word its search visits, staying on a word for each used frame met inside it,
// then reads and writes each word of the run. One request is in flight at a time; 64 words.
// Throughput is set by the word-by-word walk through the bitmap memory and the one word unit.
// Reset (asynchronous, active low) frees every frame at once through per-word valid bits,
// sets range_start to 0 and range_limit to 4096; no clearing pass is needed.

module bitmap_frame_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request words.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [11:0] first_frame, [24:12] frame_count
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
  // Result words.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [11:0] frame_index, [12] status
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_OUT
  } state_e;

  state_e             state_q;
  logic               op_write_q;  // walking words to set or clear a run
  logic               set_bits_q;
  logic [FRAME_W-1:0] f_q;
  logic [FRAME_W-1:0] end_q;
  logic [FRAME_W-1:0] run_q;
  logic [FRAME_W-1:0] cand_q;
  logic [FRAME_W-1:0] count_q;
  logic [INDEX_W-1:0] last_q;
  logic [INDEX_W-1:0] res_index_q;
  logic               res_status_q;
  logic               out_valid_q;
  logic [INDEX_W-1:0] out_index_q;
  logic               out_status_q;

  logic [INDEX_W-1:0] range_start_q;
  logic [FRAME_W-1:0] range_limit_q;

  logic [MODE_W-1:0]    in_mode;
  logic [INDEX_W-1:0]   in_first;
  logic [FRAME_W-1:0]   in_count;
  logic [FRAME_W:0]     in_last;
  logic [FRAME_W-1:0]   eff_end;
  logic [FRAME_W-1:0]   cand_last;
  logic                 cfg_write;
  logic                 accept;
  logic                 out_free;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] wr_word;
  scan_step_t           step;

  assign in_mode  = s_axis_tuser;
  assign in_first = s_axis_tdata[11:0];
  assign in_count = s_axis_tdata[24:12];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The search ends at range_limit, or at the end of the map if that comes first.
  assign eff_end = (range_limit_q > MAP_END) ? MAP_END : range_limit_q;

  // Last frame of a free or mark run, clipped to the map; only used when the count is non-zero.
  // The sum is one bit wider so that a long run from a high start cannot wrap.
  assign in_last   = {2'b00, in_first} + {1'b0, in_count} - (FRAME_W + 1)'(1);
  assign cand_last = cand_q + count_q - FRAME_W'(1);

  // Configuration registers; the word select only looks at the register bit of the address.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= '0;
      range_limit_q <= MAP_END;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_RANGE_START: range_start_q <= pwdata[INDEX_W-1:0];
        REG_RANGE_LIMIT: range_limit_q <= pwdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RANGE_START: prdata = 32'(range_start_q);
      REG_RANGE_LIMIT: prdata = 32'(range_limit_q);
      default:         prdata = '0;
    endcase
  end

  // The bitmap memory: one word read into a register in S_READ, written back in S_EVAL while a run is set or cleared.
  assign wr_word = set_bits_q ? (word | mask) : (word & ~mask);

  bfa_bitmap_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (state_q == S_READ),
    .rd_addr_i (f_q[INDEX_W-1:WORD_AW]),
    .rd_data_o (word),
    .wr_en_i   ((state_q == S_EVAL) && op_write_q),
    .wr_addr_i (f_q[INDEX_W-1:WORD_AW]),
    .wr_data_i (wr_word)
  );

  // The shared word unit does one search step or builds one write mask per cycle in S_EVAL.
  bfa_word_unit u_unit (
    .word_i  (word),
    .f_i     (f_q),
    .end_i   (end_q),
    .run_i   (run_q),
    .cand_i  (cand_q),
    .count_i (count_q),
    .last_i  (last_q),
    .step_o  (step),
    .mask_o  (mask)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer. An allocate first searches, then turns into a mark of the run it found.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_write_q   <= 1'b0;
      set_bits_q   <= 1'b0;
      f_q          <= '0;
      end_q        <= '0;
      run_q        <= '0;
      cand_q       <= '0;
      count_q      <= '0;
      last_q       <= '0;
      res_index_q  <= '0;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
      out_index_q  <= '0;
      out_status_q <= ST_OK;
    end else begin
      // In S_OUT a taken word is replaced by the next one below.
      if (m_axis_tvalid && m_axis_tready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_index_q  <= '0;
            res_status_q <= ST_OK;
            count_q      <= in_count;
            if (in_mode == MODE_ALLOC) begin
              if (in_count == '0) begin
                // A zero-length allocate only reports the range start.
                res_index_q <= range_start_q;
                state_q     <= S_OUT;
              end else if ({1'b0, range_start_q} >= eff_end) begin
                res_status_q <= ST_OOM;
                state_q      <= S_OUT;
              end else begin
                op_write_q <= 1'b0;
                f_q        <= {1'b0, range_start_q};
                cand_q     <= {1'b0, range_start_q};
                end_q      <= eff_end;
                run_q      <= '0;
                state_q    <= S_READ;
              end
            end else if ((in_mode == MODE_FREE || in_mode == MODE_MARK) &&
                         in_count != '0) begin
              op_write_q <= 1'b1;
              set_bits_q <= (in_mode == MODE_MARK);
              f_q        <= {1'b0, in_first};
              last_q     <= (in_last > {1'b0, LAST_FRAME}) ? LAST_FRAME[INDEX_W-1:0] :
                            in_last[INDEX_W-1:0];
              state_q    <= S_READ;
            end else begin
              state_q <= S_OUT;
            end
          end
        end

        S_READ: begin
          state_q <= S_EVAL;
        end

        S_EVAL: begin
          if (op_write_q) begin
            if (f_q[INDEX_W-1:WORD_AW] == last_q[INDEX_W-1:WORD_AW]) begin
              state_q <= S_OUT;
            end else begin
              f_q     <= {f_q[FRAME_W-1:WORD_AW] + (FRAME_W - WORD_AW)'(1), WORD_AW'(0)};
              state_q <= S_READ;
            end
          end else if (step.found) begin
            // The run starting at the candidate is free; go back and mark it used.
            res_index_q <= cand_q[INDEX_W-1:0];
            op_write_q  <= 1'b1;
            set_bits_q  <= 1'b1;
            f_q         <= cand_q;
            last_q      <= cand_last[INDEX_W-1:0];
            state_q     <= S_READ;
          end else if (step.next_f >= end_q) begin
            res_status_q <= ST_OOM;
            state_q      <= S_OUT;
          end else begin
            f_q    <= step.next_f;
            run_q  <= step.next_run;
            cand_q <= step.next_cand;
            // Stay on the held word while the search remains inside it.
            if (step.next_f[FRAME_W-1:WORD_AW] != f_q[FRAME_W-1:WORD_AW]) begin
              state_q <= S_READ;
            end
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_index_q  <= res_index_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_status_q, out_index_q};

endmodule

`default_nettype wire

// ===== verif/bitmap_frame_allocator_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, result and configuration channels, keeps its own copy of
// the usage bitmap and the range registers, and checks each result word.
module bitmap_frame_allocator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [11:0] first_frame, [24:12] frame_count
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [11:0] frame_index, [12] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          awaited_o
);
  import bfa_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] frame_index;
    logic               status;
  } alloc_result_t;

  bit [FRAME_TOTAL-1:0] used_map;
  logic [INDEX_W-1:0]   range_start_q;
  logic [FRAME_W-1:0]   range_limit_q;
  alloc_result_t        awaited_results[$];
  alloc_result_t        oldest;
  int                   mismatches = 0;
  int                   awaited = 0;

  assign fail_count_o = mismatches;
  assign awaited_o    = awaited;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void write_run(int unsigned first, int unsigned count, bit used);
    int unsigned f;
    for (int unsigned i = 0; i < count; i++) begin
      f = first + i;
      if (f < FRAME_TOTAL) used_map[f[INDEX_W-1:0]] = used;
    end
  endfunction

  // First-fit search and bitmap update for one request.
  function automatic alloc_result_t serve_request(logic [MODE_W-1:0] mode,
                                                  logic [INDEX_W-1:0] first,
                                                  logic [FRAME_W-1:0] count);
    alloc_result_t res;
    int unsigned   end_f;
    int unsigned   cand;
    int unsigned   run_len;
    bit            found;
    res     = '{frame_index: '0, status: ST_OK};
    found   = 1'b0;
    run_len = 0;
    if (mode == MODE_ALLOC) begin
      if (count == 0) begin
        res.frame_index = range_start_q;
      end else begin
        end_f = (range_limit_q > FRAME_TOTAL) ? FRAME_TOTAL : 32'(range_limit_q);
        cand  = 32'(range_start_q);
        for (int unsigned f = 32'(range_start_q); f < end_f && !found; f++) begin
          if (used_map[f[INDEX_W-1:0]]) begin
            run_len = 0;
            cand    = f + 1;
          end else begin
            run_len++;
            if (run_len == 32'(count)) found = 1'b1;
          end
        end
        if (found) begin
          write_run(cand, 32'(count), 1'b1);
          res.frame_index = INDEX_W'(cand);
        end else begin
          res.status = ST_OOM;
        end
      end
    end else if (mode == MODE_FREE) begin
      write_run(32'(first), 32'(count), 1'b0);
    end else if (mode == MODE_MARK) begin
      write_run(32'(first), 32'(count), 1'b1);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      used_map      = '0;
      range_start_q = '0;
      range_limit_q = MAP_END;
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_RANGE_START) range_start_q = pwdata[INDEX_W-1:0];
        else range_limit_q = pwdata[FRAME_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(serve_request(s_axis_tuser, s_axis_tdata[11:0],
                                                s_axis_tdata[24:12]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with no request awaiting it",
                          32'(m_axis_tdata[12:0]), 0);
        end else begin
          oldest = awaited_results.pop_front();
          if (m_axis_tdata[11:0] !== oldest.frame_index)
            report_mismatch("frame_index", 32'(m_axis_tdata[11:0]),
                            32'(oldest.frame_index));
          if (m_axis_tdata[12] !== oldest.status)
            report_mismatch("status", 32'(m_axis_tdata[12]), 32'(oldest.status));
        end
      end
    end
    awaited = awaited_results.size();
  end

endmodule

// ===== verif/bitmap_frame_allocator_tb.sv =====
`timescale 1ns / 100ps

// Top of the allocator testbench. It makes the clock, the single reset, the
// request words, the range register writes and the back-pressure on the result
// channel. All prediction and comparison happens in the checker beside the block;
// this module only reads its failure count and the number of results still
// awaited, and gives the verdict.
module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [11:0] first_frame, [24:12] frame_count
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [11:0] frame_index, [12] status
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int awaited;

  // When set, neither side idles any more: the closing stretch runs flat out.
  bit quiet = 1'b0;

  bitmap_frame_allocator DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bitmap_frame_allocator_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count),
    .awaited_o(awaited)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // A generous ceiling: the worst allocate walks the whole map and meets a used
  // frame at every step.
  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result-side back-pressure. Now and then tready drops for a burst; the burst
  // length is held in a counter so that tready gets exactly one assignment at
  // each falling edge.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every task below is entered just after a falling edge and returns just
  // after one, so inputs always change half a period away from the sampling edge.

  // Sends one request word. An optional idle burst comes first; tvalid is only
  // lowered there, so back-to-back words keep it high without a glitch.
  task automatic send_word(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] first,
                           logic [FRAME_W-1:0] count);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'b0, count, first};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops sending and waits until the checker has seen every awaited result,
  // which leaves the block idle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
  endtask

  // One APB write: setup cycle, then access cycle until pready. The bits above
  // the register width carry random junk, which the block must ignore.
  task automatic write_register(logic reg_index, logic [FRAME_W-1:0] value);
    logic [31:0] junk;
    junk = $urandom;
    if (reg_index == REG_RANGE_START) junk[INDEX_W-1:0] = value[INDEX_W-1:0];
    else junk[FRAME_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= junk;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Both range registers are only touched once the block has gone idle.
  task automatic set_range(logic [INDEX_W-1:0] start, logic [FRAME_W-1:0] limit);
    drain_results();
    write_register(REG_RANGE_START, start);
    write_register(REG_RANGE_LIMIT, limit);
  endtask

  // One random request. Allocates dominate, mostly small so that the search
  // stays short and the map fills and empties in a lively way; frees come with
  // wider runs so that space keeps coming back. Now and then a count or a run
  // goes past the end of the map, and a few words carry the unused mode.
  task automatic random_request();
    int unsigned pick;
    int unsigned size_pick;
    logic [FRAME_W-1:0] count;
    pick      = $urandom_range(0, 99);
    size_pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if (size_pick < 4) count = '0;
      else if (size_pick < 64) count = FRAME_W'($urandom_range(1, 8));
      else if (size_pick < 89) count = FRAME_W'($urandom_range(9, 128));
      else if (size_pick < 97) count = FRAME_W'($urandom_range(129, 4096));
      else count = FRAME_W'($urandom_range(4097, 8191));
      send_word(MODE_ALLOC, INDEX_W'($urandom), count);
    end else if (pick < 78) begin
      if (size_pick < 70) count = FRAME_W'($urandom_range(1, 64));
      else if (size_pick < 90) count = FRAME_W'($urandom_range(65, 1024));
      else count = FRAME_W'($urandom);
      send_word(MODE_FREE, INDEX_W'($urandom), count);
    end else if (pick < 95) begin
      if (size_pick < 90) count = FRAME_W'($urandom_range(0, 32));
      else count = FRAME_W'($urandom);
      send_word(MODE_MARK, INDEX_W'($urandom), count);
    end else begin
      send_word(MODE_UNUSED, INDEX_W'($urandom), FRAME_W'($urandom));
    end
  endtask

  initial begin
    logic [INDEX_W-1:0] starts[8];
    logic [FRAME_W-1:0] limits[8];

    // Ranges of the random phases: the reset values (twice), a window in the
    // middle, a limit past the map, the last word only, the first word only,
    // and two random windows; only the first may be empty or inverted.
    starts = '{12'd0, 12'd1000, 12'd0,   12'd3968, 12'd0,  12'd0, 12'd0, 12'd0};
    limits = '{13'd4096, 13'd3000, 13'd8191, 13'd4096, 13'd64, 13'd0, 13'd0, 13'd4096};
    starts[5] = INDEX_W'($urandom);
    limits[5] = FRAME_W'($urandom);
    starts[6] = INDEX_W'($urandom_range(0, 2047));
    limits[6] = FRAME_W'($urandom_range(2048, 4200));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, on the reset range first.
    send_word(MODE_ALLOC, 12'd0, 13'd0);        // zero-length allocate gives range_start
    send_word(MODE_ALLOC, 12'd0, 13'd1);
    send_word(MODE_ALLOC, 12'd0, 13'd5);
    send_word(MODE_MARK, 12'd10, 13'd3);
    send_word(MODE_ALLOC, 12'd0, 13'd4);        // fits exactly in the gap before the marked frames
    send_word(MODE_ALLOC, 12'd0, 13'd8);
    send_word(MODE_FREE, 12'd0, 13'd2);
    send_word(MODE_ALLOC, 12'd4095, 13'd2);     // first_frame is ignored on allocate
    send_word(MODE_UNUSED, 12'd4095, 13'd8191); // unused mode leaves the map alone
    send_word(MODE_MARK, 12'd4090, 13'd8191);   // frames past the map are dropped
    send_word(MODE_ALLOC, 12'd0, 13'd4096);     // cannot fit: out of memory
    send_word(MODE_FREE, 12'd0, 13'd8191);
    send_word(MODE_ALLOC, 12'd0, 13'd4096);     // whole map in one run
    send_word(MODE_ALLOC, 12'd0, 13'd8191);
    send_word(MODE_FREE, 12'd4095, 13'd1);
    send_word(MODE_ALLOC, 12'd0, 13'd1);        // the very last frame
    send_word(MODE_ALLOC, 12'd0, 13'd1);
    send_word(MODE_FREE, 12'd0, 13'd4096);

    // Last frame only, with a limit past the map.
    set_range(12'd4095, 13'd8191);
    send_word(MODE_ALLOC, 12'd0, 13'd1);
    send_word(MODE_ALLOC, 12'd0, 13'd1);
    send_word(MODE_ALLOC, 12'd0, 13'd0);
    // An inverted window and then an empty one: only zero-length succeeds.
    set_range(12'd100, 13'd50);
    send_word(MODE_ALLOC, 12'd0, 13'd1);
    send_word(MODE_ALLOC, 12'd0, 13'd0);
    set_range(12'd0, 13'd0);
    send_word(MODE_ALLOC, 12'd0, 13'd1);
    send_word(MODE_FREE, 12'd0, 13'd4096);

    // Random phases. Half of them start from an empty map; the others carry
    // over whatever the previous phase left behind. The last one runs with no
    // idling on either side.
    for (int phase = 0; phase < 8; phase++) begin
      set_range(starts[phase], limits[phase]);
      if (phase == 7) quiet = 1'b1;
      if (phase % 2 == 0) send_word(MODE_FREE, 12'd0, 13'd4096);
      for (int n = 0; n < 88; n++) begin
        random_request();
        // Now and then the sender holds off until every result is back.
        if (n % 29 == 28) drain_results();
      end
    end

    drain_results();
    // A little more than the longest request the block can be working on.
    repeat (5000) @(negedge clk_i);
    if (fail_count == 0 && awaited == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
